// ----- hdl/tensor_axis_permute_addresses_top_macros.svh -----
// Assertion macros for the axis-permute address generator.
// Included by the top level; needs nothing else.
`ifndef TENSOR_AXIS_PERMUTE_ADDRESSES_TOP_MACROS_SVH
`define TENSOR_AXIS_PERMUTE_ADDRESSES_TOP_MACROS_SVH

// same-cycle implication
`define TAPA_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TAPA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/tapa_pkg.sv -----
// Shared types and constants for the axis-permute address generator.
// No dependencies; used by the channel interfaces and the top level.
package tapa_pkg;

   localparam int VALUE_WIDTH       = 32;
   localparam int ADDR_WIDTH        = 32;
   localparam int CSR_DATA_WIDTH    = 32;
   localparam int RANK_WIDTH        = 3;
   localparam int SIZES_WIDTH       = 32;
   localparam int ORDER_WIDTH       = 8;
   localparam int ORDER_FIELD_WIDTH = 2;
   localparam int HW_AXES           = 4;

   typedef logic [VALUE_WIDTH-1:0]       value_type;
   typedef logic [ADDR_WIDTH-1:0]        addr_type;
   typedef logic [CSR_DATA_WIDTH-1:0]    csr_data_type;
   typedef logic [ORDER_FIELD_WIDTH-1:0] axis_sel_type;

   typedef enum logic [1:0] {
      CSR_TENSOR_RANK = 2'd0,
      CSR_AXIS_SIZES  = 2'd1,
      CSR_AXIS_ORDER  = 2'd2
   } csr_index_type;

   localparam logic [RANK_WIDTH-1:0]  RANK_RESET  = 3'd1;
   localparam logic [SIZES_WIDTH-1:0] SIZES_RESET = 32'd0;
   localparam logic [ORDER_WIDTH-1:0] ORDER_RESET = 8'd228;

endpackage

// ----- hdl/tapa_channels.sv -----
// Valid/ready channel interfaces: element input, address result, register write.
// Depends on tapa_pkg.
interface tapa_req_if;
   logic                 valid;
   logic                 ready;
   tapa_pkg::value_type  element_value;

   modport source (output valid, output element_value, input ready);
   modport sink   (input valid, input element_value, output ready);
endinterface

interface tapa_rsp_if;
   logic                 valid;
   logic                 ready;
   tapa_pkg::addr_type   dest_address;
   tapa_pkg::value_type  moved_value;
   logic                 final_element;

   modport source (output valid, output dest_address, output moved_value,
                   output final_element, input ready);
   modport sink   (input valid, input dest_address, input moved_value,
                   input final_element, output ready);
endinterface

interface tapa_csr_if;
   logic                     valid;
   logic                     ready;
   tapa_pkg::csr_index_type  index;
   tapa_pkg::csr_data_type   data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/tensor_axis_permute_addresses_top.sv -----
// Channel    | dir | payload
// req_port   | in  | element_value
// rsp_port   | out | dest_address, moved_value, final_element
// csr_port   | in  | index, data (tensor_rank, axis_sizes_minus_one, axis_order)
//
// One transaction per cycle sustained while rsp_port.ready stays high and the strides have settled;
// an accepted element passes the input stage, the per-axis stride multiply and the address sum
// into the output register. Reset is synchronous; after reset or any csr write, req_port.ready
// stays low while the stride register chain (one multiply per axis below the last) settles.
// Each stage holds while the one after it is full and stalled.
// Axis-permute address generator top level. Depends on tapa_pkg, tapa_channels
// and tensor_axis_permute_addresses_top_macros.svh.
`include "tensor_axis_permute_addresses_top_macros.svh"

module tensor_axis_permute_addresses_top #(
   parameter int RANK_LIMIT = 4,
   parameter int AXIS_BITS  = 8,
   parameter int VALUE_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   tapa_req_if.sink   req_port,
   tapa_rsp_if.source rsp_port,
   tapa_csr_if.sink   csr_port
);

   localparam int ADDR_W   = tapa_pkg::ADDR_WIDTH;
   localparam int VAL_W    = tapa_pkg::VALUE_WIDTH;
   localparam int DSIZE_W  = AXIS_BITS + 1;
   localparam int SP_W     = ADDR_W + DSIZE_W;
   localparam int TP_W     = ADDR_W + AXIS_BITS;
   localparam int SETTLE_W = $clog2(RANK_LIMIT + 1);
   localparam logic [VAL_W-1:0] VALUE_MASK =
      (VALUE_BITS >= VAL_W) ? {VAL_W{1'b1}} : VAL_W'((64'd1 << VALUE_BITS) - 64'd1);

   logic [tapa_pkg::RANK_WIDTH-1:0]  rank_ff;
   logic [tapa_pkg::SIZES_WIDTH-1:0] sizes_ff;
   logic [tapa_pkg::ORDER_WIDTH-1:0] order_ff;
   logic [SETTLE_W-1:0]              settle_ff;

   logic [3:0] rank_ext;
   logic [3:0] arank;

   logic [RANK_LIMIT-1:0][AXIS_BITS-1:0] coord_ff;
   logic [RANK_LIMIT-1:0][AXIS_BITS-1:0] coord_in;
   logic [RANK_LIMIT-1:0][AXIS_BITS-1:0] smo;
   tapa_pkg::axis_sel_type               order_src [RANK_LIMIT];
   logic [DSIZE_W-1:0]                   dsize     [RANK_LIMIT];
   logic [ADDR_W-1:0]                    stride_ff [RANK_LIMIT];
   logic [ADDR_W-1:0]                    stride_in [RANK_LIMIT];
   logic [AXIS_BITS-1:0]                 dcoord_in [RANK_LIMIT];
   logic [RANK_LIMIT-1:0]                top_axis;
   logic [RANK_LIMIT-1:0]                in_use;
   logic                                 last_in;
   logic                                 carry;

   logic                 s1_valid_ff;
   logic [VAL_W-1:0]     s1_value_ff;
   logic [AXIS_BITS-1:0] s1_dcoord_ff [RANK_LIMIT];
   logic                 s1_last_ff;

   logic                 s2_valid_ff;
   logic [VAL_W-1:0]     s2_value_ff;
   logic [ADDR_W-1:0]    s2_term_ff [RANK_LIMIT];
   logic [ADDR_W-1:0]    s2_term_in [RANK_LIMIT];
   logic                 s2_last_ff;

   logic                 rsp_valid_ff;
   logic [ADDR_W-1:0]    rsp_addr_ff;
   logic [ADDR_W-1:0]    rsp_addr_in;
   logic [VAL_W-1:0]     rsp_value_ff;
   logic                 rsp_last_ff;

   logic s3_ready, s2_ready, s1_ready;
   logic out_load, s2_load, req_fire, csr_fire;

   // handshake
   assign s3_ready = !rsp_valid_ff || rsp_port.ready;
   assign out_load = s2_valid_ff && s3_ready;
   assign s2_ready = !s2_valid_ff || s3_ready;
   assign s2_load  = s1_valid_ff && s2_ready;
   assign s1_ready = !s1_valid_ff || s2_ready;

   assign req_port.ready = s1_ready && (settle_ff == '0);
   assign req_fire       = req_port.valid && req_port.ready;
   assign csr_port.ready = 1'b1;
   assign csr_fire       = csr_port.valid && csr_port.ready;

   assign rsp_port.valid         = rsp_valid_ff;
   assign rsp_port.dest_address  = rsp_addr_ff;
   assign rsp_port.moved_value   = rsp_value_ff;
   assign rsp_port.final_element = rsp_last_ff;

   // clamp rank
   always_comb begin
      rank_ext = {1'b0, rank_ff};
      if (rank_ext == 4'd0) begin
         arank = 4'd1;
      end else if (rank_ext > 4'(RANK_LIMIT)) begin
         arank = 4'(RANK_LIMIT);
      end else begin
         arank = rank_ext;
      end
   end

   // per-axis fields from the csr registers
   for (genvar a = 0; a < RANK_LIMIT; a++) begin : g_field
      if (a < tapa_pkg::HW_AXES && a * AXIS_BITS < tapa_pkg::SIZES_WIDTH) begin : g_size
         assign smo[a] = AXIS_BITS'(sizes_ff >> (a * AXIS_BITS));
      end else begin : g_size_none
         assign smo[a] = '0;
      end
      if (a < tapa_pkg::HW_AXES) begin : g_order
         assign order_src[a] =
            order_ff[a*tapa_pkg::ORDER_FIELD_WIDTH +: tapa_pkg::ORDER_FIELD_WIDTH];
      end else begin : g_order_none
         assign order_src[a] = '0;
      end
   end

   // destination size and coordinate per destination axis
   always_comb begin
      for (int j = 0; j < RANK_LIMIT; j++) begin
         dsize[j]     = DSIZE_W'(1);
         dcoord_in[j] = '0;
         if (4'(j) < arank && {2'b00, order_src[j]} < arank) begin
            for (int i = 0; i < RANK_LIMIT; i++) begin
               if (int'(order_src[j]) == i) begin
                  dsize[j]     = DSIZE_W'(smo[i]) + DSIZE_W'(1);
                  dcoord_in[j] = coord_ff[i];
               end
            end
         end
      end
   end

   // stride chain: stride of destination axis j is the product of later sizes
   for (genvar j = 0; j < RANK_LIMIT; j++) begin : g_stride
      if (j == RANK_LIMIT - 1) begin : g_last
         assign stride_in[j] = ADDR_W'(1);
      end else begin : g_mul
         assign stride_in[j] = ADDR_W'(SP_W'(stride_ff[j+1]) * SP_W'(dsize[j+1]));
      end
   end

   // source coordinate counter
   always_comb begin
      last_in  = 1'b1;
      carry    = 1'b1;
      coord_in = coord_ff;
      for (int i = 0; i < RANK_LIMIT; i++) begin
         in_use[i]   = 4'(i) < arank;
         top_axis[i] = coord_ff[i] >= smo[i];
         if (in_use[i] && !top_axis[i]) begin
            last_in = 1'b0;
         end
      end
      for (int i = RANK_LIMIT - 1; i >= 0; i--) begin
         if (in_use[i]) begin
            if (carry) begin
               coord_in[i] = top_axis[i] ? '0 : coord_ff[i] + AXIS_BITS'(1);
            end
            carry = carry && top_axis[i];
         end
      end
      if (last_in) begin
         coord_in = '0;
      end
   end

   always_comb begin
      for (int j = 0; j < RANK_LIMIT; j++) begin
         s2_term_in[j] = ADDR_W'(TP_W'(s1_dcoord_ff[j]) * TP_W'(stride_ff[j]));
      end
   end

   always_comb begin
      rsp_addr_in = '0;
      for (int j = 0; j < RANK_LIMIT; j++) begin
         rsp_addr_in = rsp_addr_in + s2_term_ff[j];
      end
   end

   // control and csr state
   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff      <= tapa_pkg::RANK_RESET;
         sizes_ff     <= tapa_pkg::SIZES_RESET;
         order_ff     <= tapa_pkg::ORDER_RESET;
         settle_ff    <= SETTLE_W'(RANK_LIMIT);
         coord_ff     <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_fire) begin
            settle_ff <= SETTLE_W'(RANK_LIMIT);
            case (csr_port.index)
               tapa_pkg::CSR_TENSOR_RANK: rank_ff  <= csr_port.data[tapa_pkg::RANK_WIDTH-1:0];
               tapa_pkg::CSR_AXIS_SIZES:  sizes_ff <= csr_port.data[tapa_pkg::SIZES_WIDTH-1:0];
               tapa_pkg::CSR_AXIS_ORDER:  order_ff <= csr_port.data[tapa_pkg::ORDER_WIDTH-1:0];
               default: begin
               end
            endcase
         end else if (settle_ff != '0) begin
            settle_ff <= settle_ff - SETTLE_W'(1);
         end
         if (req_fire) begin
            coord_ff <= coord_in;
         end
         if (s1_ready) begin
            s1_valid_ff <= req_fire;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_port.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      stride_ff <= stride_in;
      if (req_fire) begin
         s1_value_ff  <= req_port.element_value & VALUE_MASK;
         s1_dcoord_ff <= dcoord_in;
         s1_last_ff   <= last_in;
      end
      if (s2_load) begin
         s2_value_ff <= s1_value_ff;
         s2_term_ff  <= s2_term_in;
         s2_last_ff  <= s1_last_ff;
      end
      if (out_load) begin
         rsp_addr_ff  <= rsp_addr_in;
         rsp_value_ff <= s2_value_ff;
         rsp_last_ff  <= s2_last_ff;
      end
   end

   `TAPA_ASSERT_NOW(a_settle_blocks_req, clock, reset, settle_ff != '0, !req_port.ready, "req accepted while strides settle")
   `TAPA_ASSERT_NEXT(a_final_clears_coord, clock, reset, req_fire && last_in, coord_ff == '0, "counter not cleared after final element")
   `TAPA_ASSERT_NEXT(a_csr_restarts_settle, clock, reset, csr_fire, settle_ff == SETTLE_W'(RANK_LIMIT), "csr write did not restart settle")
   `TAPA_ASSERT_NEXT(a_stall_holds_s2, clock, reset, s2_valid_ff && !s3_ready, s2_valid_ff && $stable(s2_last_ff), "stage 2 lost a transaction under stall")

endmodule

// ----- verif/testbench.sv -----
// Self-checking testbench for tensor_axis_permute_addresses_top: streams tensor elements
// under many rank/size/order settings and checks every permuted address against a model.
// Depends on tapa_pkg, tapa_channels and the top level RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          AXIS_FIELD   = 8;
   localparam int          RANK_BITS    = tapa_pkg::RANK_WIDTH;
   localparam int unsigned STALL_LIMIT  = 1000;
   localparam int unsigned HOLD_CYCLES  = 150;
   localparam int unsigned DRAIN_SLACK  = 8;
   localparam int unsigned TARGET_ITEMS = 700;
   localparam tapa_pkg::csr_index_type CSR_UNMAPPED = tapa_pkg::csr_index_type'(2'd3);

   typedef struct {
      tapa_pkg::addr_type  dest_address;
      tapa_pkg::value_type moved_value;
      logic                final_element;
   } placement_type;

   class permute_scoreboard;
      logic [tapa_pkg::RANK_WIDTH-1:0]  rank_reg;
      logic [tapa_pkg::SIZES_WIDTH-1:0] sizes_reg;
      logic [tapa_pkg::ORDER_WIDTH-1:0] order_reg;
      logic [AXIS_FIELD-1:0]            coord [tapa_pkg::HW_AXES];
      placement_type                    expected [$];
      int unsigned                      mismatches;

      function new();
         rank_reg   = tapa_pkg::RANK_RESET;
         sizes_reg  = tapa_pkg::SIZES_RESET;
         order_reg  = tapa_pkg::ORDER_RESET;
         mismatches = 0;
         foreach (coord[i]) coord[i] = '0;
      endfunction

      function void write_register(tapa_pkg::csr_index_type idx, tapa_pkg::csr_data_type data);
         case (idx)
            tapa_pkg::CSR_TENSOR_RANK: rank_reg = data[tapa_pkg::RANK_WIDTH-1:0];
            tapa_pkg::CSR_AXIS_SIZES:  sizes_reg = data[tapa_pkg::SIZES_WIDTH-1:0];
            tapa_pkg::CSR_AXIS_ORDER:  order_reg = data[tapa_pkg::ORDER_WIDTH-1:0];
            default: ;
         endcase
      endfunction

      function int unsigned pending();
         return expected.size();
      endfunction

      function void note_element(tapa_pkg::value_type value);
         int            rank;
         int            i;
         int            j;
         int unsigned   src;
         logic [63:0]   acc;
         logic [63:0]   dsize;
         logic [63:0]   dcoord;
         logic          is_last;
         placement_type entry;
         rank = rank_reg;
         if (rank < 1) rank = 1;
         if (rank > tapa_pkg::HW_AXES) rank = tapa_pkg::HW_AXES;
         acc = '0;
         for (j = 0; j < rank; j++) begin
            src    = order_reg[2*j +: 2];
            dsize  = 64'd1;
            dcoord = '0;
            if (src < rank) begin
               dsize  = 64'(sizes_reg[src*AXIS_FIELD +: AXIS_FIELD]) + 64'd1;
               dcoord = 64'(coord[src]);
            end
            acc = ((acc * dsize) + dcoord) & 64'hFFFF_FFFF;
         end
         is_last = 1'b1;
         for (i = 0; i < rank; i++)
            if (coord[i] < sizes_reg[i*AXIS_FIELD +: AXIS_FIELD]) is_last = 1'b0;
         if (is_last) begin
            foreach (coord[k]) coord[k] = '0;
         end else begin
            for (i = rank - 1; i >= 0; i--) begin
               if (coord[i] >= sizes_reg[i*AXIS_FIELD +: AXIS_FIELD]) begin
                  coord[i] = '0;
               end else begin
                  coord[i] = coord[i] + 1'b1;
                  break;
               end
            end
         end
         entry.dest_address  = acc[tapa_pkg::ADDR_WIDTH-1:0];
         entry.moved_value   = value;
         entry.final_element = is_last;
         expected.push_back(entry);
      endfunction

      task report(string msg);
         $display("%0t ns mismatch: %s", $realtime, msg);
         mismatches++;
      endtask

      task check_result(tapa_pkg::addr_type dest_address, tapa_pkg::value_type moved_value,
                        logic final_element);
         placement_type want;
         if (expected.size() == 0) begin
            report($sformatf("transaction with nothing expected: addr %h value %h final %b",
                             dest_address, moved_value, final_element));
            return;
         end
         want = expected.pop_front();
         if (dest_address !== want.dest_address)
            report($sformatf("dest_address %h, expected %h", dest_address, want.dest_address));
         if (moved_value !== want.moved_value)
            report($sformatf("moved_value %h, expected %h", moved_value, want.moved_value));
         if (final_element !== want.final_element)
            report($sformatf("final_element %b, expected %b", final_element,
                             want.final_element));
      endtask
   endclass

   logic clock = 1'b0;
   logic reset;

   tapa_req_if req_bus ();
   tapa_rsp_if rsp_bus ();
   tapa_csr_if csr_bus ();

   tensor_axis_permute_addresses_top u_top (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus),
      .csr_port (csr_bus)
   );

   permute_scoreboard sb = new();

   int unsigned                      idle_cycles = 0;
   int unsigned                      items_sent = 0;
   bit                               idle_free = 1'b0;
   bit                               hold_request = 1'b0;
   bit                               progress;
   logic [tapa_pkg::RANK_WIDTH-1:0]  cur_rank = tapa_pkg::RANK_RESET;
   logic [tapa_pkg::SIZES_WIDTH-1:0] cur_sizes = tapa_pkg::SIZES_RESET;

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (!reset) begin
         progress = 1'b0;
         if (req_bus.valid && req_bus.ready) begin
            sb.note_element(req_bus.element_value);
            progress = 1'b1;
         end
         if (csr_bus.valid && csr_bus.ready) begin
            sb.write_register(csr_bus.index, csr_bus.data);
            progress = 1'b1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            sb.check_result(rsp_bus.dest_address, rsp_bus.moved_value, rsp_bus.final_element);
            progress = 1'b1;
         end
         idle_cycles = progress ? 0 : idle_cycles + 1;
      end
   end

   initial begin : watchdog
      do @(posedge clock); while (idle_cycles < STALL_LIMIT);
      $display("** tensor_axis_permute_addresses_top: FAILED **");
      $finish;
   end

   function automatic int unsigned draw_gap();
      return idle_free ? 0 : $urandom_range(0, 13);
   endfunction

   function automatic longint unsigned tensor_elements(
         logic [tapa_pkg::RANK_WIDTH-1:0] rank_d, logic [tapa_pkg::SIZES_WIDTH-1:0] sizes_d);
      int               rank;
      longint unsigned  count;
      rank = rank_d;
      if (rank < 1) rank = 1;
      if (rank > tapa_pkg::HW_AXES) rank = tapa_pkg::HW_AXES;
      count = 1;
      for (int i = 0; i < rank; i++)
         count = count * (longint'(sizes_d[i*AXIS_FIELD +: AXIS_FIELD]) + 1);
      return count;
   endfunction

   function automatic logic [tapa_pkg::ORDER_WIDTH-1:0] random_permutation();
      int unsigned                      perm [tapa_pkg::HW_AXES];
      int unsigned                      k;
      int unsigned                      swap;
      logic [tapa_pkg::ORDER_WIDTH-1:0] order_d;
      foreach (perm[i]) perm[i] = i;
      for (int i = tapa_pkg::HW_AXES - 1; i > 0; i--) begin
         k       = $urandom_range(0, i);
         swap    = perm[i];
         perm[i] = perm[k];
         perm[k] = swap;
      end
      foreach (perm[i]) order_d[2*i +: 2] = perm[i][1:0];
      return order_d;
   endfunction

   function automatic logic [AXIS_FIELD-1:0] random_axis_size();
      case ($urandom_range(0, 19))
         0, 1:          return AXIS_FIELD'($urandom);
         2, 3, 4, 5, 6: return AXIS_FIELD'($urandom_range(0, 5));
         default:       return AXIS_FIELD'($urandom_range(0, 2));
      endcase
   endfunction

   initial begin : result_sink
      int unsigned gap;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (hold_request) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_request = 1'b0;
         end
         gap = draw_gap();
         if (gap > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   task automatic send_element(tapa_pkg::value_type value);
      int unsigned gap;
      gap = draw_gap();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.element_value <= value;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
   endtask

   task automatic wait_drain();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   task automatic csr_write(tapa_pkg::csr_index_type idx, tapa_pkg::csr_data_type data);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      do @(posedge clock); while (!csr_bus.ready);
   endtask

   // which: bit 0 rank, bit 1 sizes, bit 2 order
   task automatic load_settings(logic [2:0] which, tapa_pkg::csr_data_type rank_d,
                                tapa_pkg::csr_data_type sizes_d,
                                tapa_pkg::csr_data_type order_d);
      wait_drain();
      if (which[0]) begin
         csr_write(tapa_pkg::CSR_TENSOR_RANK, rank_d);
         cur_rank = rank_d[tapa_pkg::RANK_WIDTH-1:0];
      end
      if (which[1]) begin
         csr_write(tapa_pkg::CSR_AXIS_SIZES, sizes_d);
         cur_sizes = sizes_d;
      end
      if (which[2]) csr_write(tapa_pkg::CSR_AXIS_ORDER, order_d);
      csr_bus.valid <= 1'b0;
   endtask

   initial begin : stimulus
      int unsigned            phase;
      int unsigned            count;
      longint unsigned        elements;
      logic [2:0]             which;
      tapa_pkg::csr_data_type rank_d;
      tapa_pkg::csr_data_type sizes_d;
      tapa_pkg::csr_data_type order_d;
      tapa_pkg::value_type    value;

      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.element_value <= '0;
      csr_bus.valid         <= 1'b0;
      csr_bus.index         <= tapa_pkg::CSR_TENSOR_RANK;
      csr_bus.data          <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: rank 1, single element per tensor
      send_element(32'h0000_0000);
      send_element(32'hFFFF_FFFF);
      send_element(32'hAAAA_AAAA);
      send_element(32'h5555_5555);

      // 2x3 tensor with the two axes swapped
      load_settings(3'b111, 32'd2, 32'h0000_0201, 32'h0000_00E1);
      repeat (6) send_element($urandom);

      // rank zero acts as one; upper data bits ignored
      load_settings(3'b111, 32'hFFFF_FFF8, 32'h0000_00FF, 32'hFFFF_FF00);
      repeat (2) send_element($urandom);

      // rank above the limit, largest sizes, reversed order
      load_settings(3'b111, 32'd7, 32'hFFFF_FFFF, 32'h0000_001B);
      repeat (3) send_element($urandom);

      // shrink sizes mid-tensor: coordinates above the top carry
      load_settings(3'b010, '0, 32'h0101_0101, '0);
      repeat (2) send_element($urandom);

      // order naming only unused axes
      load_settings(3'b111, 32'd2, 32'h0000_0102, 32'h0000_00FF);
      repeat (2) send_element($urandom);

      // duplicate axes in the order
      load_settings(3'b100, '0, '0, 32'h0000_0000);
      repeat (2) send_element($urandom);

      wait_drain();
      csr_write(CSR_UNMAPPED, 32'hFFFF_FFFF);
      csr_bus.valid <= 1'b0;

      phase = 0;
      while (items_sent < TARGET_ITEMS) begin
         if ($urandom_range(0, 9) != 0) begin
            which = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(1, 7)) : 3'b111;
            rank_d = $urandom;
            rank_d[RANK_BITS-1:0] = ($urandom_range(0, 4) == 0) ?
               RANK_BITS'($urandom_range(0, 7)) : RANK_BITS'($urandom_range(1, 4));
            if ($urandom_range(0, 19) == 0) begin
               sizes_d = $urandom;
            end else begin
               for (int i = 0; i < tapa_pkg::HW_AXES; i++)
                  sizes_d[i*AXIS_FIELD +: AXIS_FIELD] = random_axis_size();
            end
            order_d = $urandom;
            if ($urandom_range(0, 4) < 3)
               order_d[tapa_pkg::ORDER_WIDTH-1:0] = random_permutation();
            load_settings(which, rank_d, sizes_d, order_d);
         end else begin
            wait_drain();
         end

         idle_free = ($urandom_range(0, 3) == 0);
         elements  = tensor_elements(cur_rank, cur_sizes);
         if ($urandom_range(0, 9) < 2)
            count = $urandom_range(1, 12);
         else if (elements <= 40)
            count = int'(elements) * $urandom_range(1, 3);
         else
            count = $urandom_range(8, 40);

         if (phase == 2) begin
            // back up the pipeline against a stalled receiver
            idle_free    = 1'b1;
            hold_request = 1'b1;
            count        = 40;
         end

         repeat (count) begin
            value = $urandom;
            case ($urandom_range(0, 19))
               0:       value = '0;
               1:       value = '1;
               default: ;
            endcase
            send_element(value);
         end
         phase++;
      end

      wait_drain();
      foreach (sb.expected[i])
         sb.report($sformatf("expected addr %h value %h never arrived",
                             sb.expected[i].dest_address, sb.expected[i].moved_value));
      if (sb.mismatches == 0) begin
         $display("** tensor_axis_permute_addresses_top: PASSED **");
      end else begin
         $display("** tensor_axis_permute_addresses_top: FAILED **");
      end
      $finish;
   end

endmodule
